// ===== design/scp_pkg.sv =====
// shared widths, register codes and cordic arctangent table for the spiral cosine pattern
package scp_pkg;

  // port field widths
  localparam int PIX_W      = 12;
  localparam int VAL_W      = 16;
  localparam int CX_W       = 12;
  localparam int FW_W       = 13;
  localparam int ARM_W      = 7;
  localparam int WR_DATA_W  = 13;
  localparam int WR_INDEX_W = 3;

  // register indexes
  localparam logic [WR_INDEX_W-1:0] REG_CENTER_X     = 3'd0;
  localparam logic [WR_INDEX_W-1:0] REG_CENTER_Y     = 3'd1;
  localparam logic [WR_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd2;
  localparam logic [WR_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd3;
  localparam logic [WR_INDEX_W-1:0] REG_ARM_COUNT    = 3'd4;

  // register reset values
  localparam logic [CX_W-1:0]  CENTER_X_RST     = 12'd0;
  localparam logic [CX_W-1:0]  CENTER_Y_RST     = 12'd0;
  localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 13'd640;
  localparam logic [FW_W-1:0]  FRAME_HEIGHT_RST = 13'd480;
  localparam logic [ARM_W-1:0] ARM_COUNT_RST    = 7'd4;

  // internal arithmetic widths
  localparam int ANG_W  = 32;   // angle accumulator, turns q.32
  localparam int ROT_W  = 33;   // cosine datapath, q2.30 plus sign
  localparam int DIV_W  = 14;   // frame_width + frame_height
  localparam int FRAC_W = 16;   // angle and phase fraction
  localparam int STAGE_MAX = 24;

  // fixed-point gains
  localparam logic [31:0] RAD_GAIN     = 32'd2050695827;  // 3/(2 pi), q0.32
  localparam logic [31:0] HALF_AMP     = 32'd2147054151;  // 0.4999, q0.32
  localparam logic signed [ROT_W-1:0] INV_GAIN_Q30 = 33'sd652032874;

  // arctangent of 2^-i in turns, q.32
  localparam logic signed [ANG_W-1:0] ATAN_TURNS [STAGE_MAX] = '{
    32'sd536870912, 32'sd316933405, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41721,     32'sd20860,
    32'sd10430,     32'sd5215,      32'sd2607,      32'sd1303,
    32'sd651,       32'sd325,       32'sd162,       32'sd81
  };

endpackage

// ===== design/scp_if.sv =====
// point and pattern value stream interfaces
interface scp_point_if import scp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] point_x;
  logic [PIX_W-1:0] point_y;
  logic             last_point;

  modport source(output valid, point_x, point_y, last_point, input ready);
  modport sink(input valid, point_x, point_y, last_point, output ready);
endinterface

interface scp_value_if import scp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] pattern_value;
  logic                    last_value;

  modport source(output valid, pattern_value, last_value, input ready);
  modport sink(input valid, pattern_value, last_value, output ready);
endinterface

// ===== design/spiral_cosine_pattern.sv =====
// Spiral cosine pattern generator: one pixel coordinate in, one signed q1.15 intensity out.
// It takes one point every clock while the output is not stalled and returns results in
// order through the chain of cells: a square root of the distance (one root bit per
// cell), a divide by width+height (one quotient bit per cell), a second square root, and
// a cordic angle chain and cordic cosine chain (one stage per cell). The whole pipeline
// holds while a result waits at the output; configuration is read directly by the cells,
// so the user must write registers only when no transaction is in flight; the block
// itself does not enforce it.
module spiral_cosine_pattern import scp_pkg::*; #(
  parameter int COORD_BITS    = 12,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [WR_INDEX_W-1:0] wr_index,
  input  logic [WR_DATA_W-1:0]  wr_data,
  scp_point_if.sink             points,
  scp_value_if.source           values
);

  localparam int C    = COORD_BITS;
  localparam int NS   = (CORDIC_STAGES < STAGE_MAX) ? CORDIC_STAGES : STAGE_MAX;
  localparam int XW   = C + 19;
  localparam int D2W  = 2 * C + 1;
  localparam int RW1  = C + 9;
  localparam int NW   = RW1 + 24;
  localparam int RW2  = (NW + 1) / 2;
  localparam int PW   = RW2 + 32;
  localparam int DLY  = RW1 + NW + RW2 + 1 - NS;
  localparam int LAT  = 1 + RW1 + NW + RW2 + 4 + NS;

  // configuration registers
  logic [CX_W-1:0]  center_x;
  logic [CX_W-1:0]  center_y;
  logic [FW_W-1:0]  frame_width;
  logic [FW_W-1:0]  frame_height;
  logic [ARM_W-1:0] arm_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= CENTER_X_RST;
      center_y     <= CENTER_Y_RST;
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      arm_count    <= ARM_COUNT_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_CENTER_X:     center_x     <= wr_data[CX_W-1:0];
        REG_CENTER_Y:     center_y     <= wr_data[CX_W-1:0];
        REG_FRAME_WIDTH:  frame_width  <= wr_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= wr_data[FW_W-1:0];
        REG_ARM_COUNT:    arm_count    <= wr_data[ARM_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: the pipeline moves unless a result is held at the output
  logic           en;
  logic [LAT-1:0] vld;

  assign en            = !vld[LAT-1] || values.ready;
  assign points.ready  = en;
  assign values.valid  = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], points.valid};
    end
  end

  // offsets from the centre
  logic [C-1:0]        px_c;
  logic [C-1:0]        py_c;
  logic [C-1:0]        cx_c;
  logic [C-1:0]        cy_c;
  logic signed [C:0]   dx_s;
  logic signed [C:0]   dy_s;
  logic signed [C:0]   ysel;
  logic [C-1:0]        adx;
  logic [C-1:0]        ady;

  assign px_c = C'(points.point_x);
  assign py_c = C'(points.point_y);
  assign cx_c = C'(center_x);
  assign cy_c = C'(center_y);
  assign dx_s = $signed({1'b0, cx_c}) - $signed({1'b0, px_c});
  assign dy_s = $signed({1'b0, cy_c}) - $signed({1'b0, py_c});
  assign adx  = dx_s[C] ? C'(-dx_s) : dx_s[C-1:0];
  assign ady  = dy_s[C] ? C'(-dy_s) : dy_s[C-1:0];
  assign ysel = dx_s[C] ? dy_s : -dy_s;

  // input stage
  logic signed [XW-1:0] a_x0;
  logic signed [XW-1:0] a_y0;
  logic [D2W-1:0]       a_dist2;
  logic                 a_vzero;
  logic                 a_vleft;
  logic                 a_dyneg;
  logic                 a_last;

  always_ff @(posedge clk) begin
    if (en) begin
      a_x0    <= XW'({adx, 16'b0});
      a_y0    <= XW'($signed({ysel, 16'b0}));
      a_dist2 <= D2W'(adx) * D2W'(adx) + D2W'(ady) * D2W'(ady);
      a_vzero <= (dx_s == '0);
      a_vleft <= !dx_s[C] && (dx_s != '0);
      a_dyneg <= dy_s[C];
      a_last  <= points.last_point;
    end
  end

  // angle chain
  logic signed [XW-1:0]    vx [NS+1];
  logic signed [XW-1:0]    vy [NS+1];
  logic signed [ANG_W-1:0] vz [NS+1];

  assign vx[0] = a_x0;
  assign vy[0] = a_y0;
  assign vz[0] = '0;

  for (genvar i = 0; i < NS; i++) begin : g_vec
    scp_vec_cell #(.XW(XW), .SHIFT(i)) u_cell (
      .clk(clk), .en(en),
      .x_in(vx[i]), .y_in(vy[i]), .z_in(vz[i]),
      .x_out(vx[i+1]), .y_out(vy[i+1]), .z_out(vz[i+1])
    );
  end

  logic [3:0] flags_d;

  scp_delay #(.W(4), .DEPTH(NS)) u_flag_dly (
    .clk(clk), .en(en),
    .d({a_vzero, a_vleft, a_dyneg, a_last}),
    .q(flags_d)
  );

  // fold the angle back to a full turn, q.16 modulo one turn
  logic [ANG_W-1:0]  z_rnd;
  logic [FRAC_W-1:0] a16;
  logic [FRAC_W:0]   a16_d;

  assign z_rnd = vz[NS] + ANG_W'(32768);

  always_comb begin
    if (flags_d[3]) begin
      a16 = flags_d[1] ? 16'hC000 : 16'h4000;
    end else if (flags_d[2]) begin
      a16 = z_rnd[ANG_W-1 -: FRAC_W] + 16'h8000;
    end else begin
      a16 = z_rnd[ANG_W-1 -: FRAC_W];
    end
  end

  scp_delay #(.W(FRAC_W + 1), .DEPTH(DLY)) u_ang_dly (
    .clk(clk), .en(en),
    .d({a16, flags_d[0]}),
    .q(a16_d)
  );

  // distance square root
  logic [2*RW1-1:0] s1_rad  [RW1+1];
  logic [RW1+1:0]   s1_rem  [RW1+1];
  logic [RW1-1:0]   s1_root [RW1+1];

  assign s1_rad[0]  = {1'b0, a_dist2, 16'b0};
  assign s1_rem[0]  = '0;
  assign s1_root[0] = '0;

  for (genvar i = 0; i < RW1; i++) begin : g_sq1
    scp_sqrt_cell #(.RW(RW1)) u_cell (
      .clk(clk), .en(en),
      .rad_in(s1_rad[i]), .rem_in(s1_rem[i]), .root_in(s1_root[i]),
      .rad_out(s1_rad[i+1]), .rem_out(s1_rem[i+1]), .root_out(s1_root[i+1])
    );
  end

  // divide by frame size
  logic [DIV_W-1:0] div_sum;
  logic [DIV_W-1:0] divisor;
  logic [NW-1:0]    dv_num [NW+1];
  logic [DIV_W-1:0] dv_rem [NW+1];

  assign div_sum   = DIV_W'(frame_width) + DIV_W'(frame_height);
  assign divisor   = (div_sum == '0) ? DIV_W'(1) : div_sum;
  assign dv_num[0] = {s1_root[RW1], 24'b0};
  assign dv_rem[0] = '0;

  for (genvar i = 0; i < NW; i++) begin : g_div
    scp_div_cell #(.NW(NW)) u_cell (
      .clk(clk), .en(en), .divisor(divisor),
      .num_in(dv_num[i]), .rem_in(dv_rem[i]),
      .num_out(dv_num[i+1]), .rem_out(dv_rem[i+1])
    );
  end

  // square root of the ratio
  logic [2*RW2-1:0] s2_rad  [RW2+1];
  logic [RW2+1:0]   s2_rem  [RW2+1];
  logic [RW2-1:0]   s2_root [RW2+1];

  assign s2_rad[0]  = (2*RW2)'(dv_num[NW]);
  assign s2_rem[0]  = '0;
  assign s2_root[0] = '0;

  for (genvar i = 0; i < RW2; i++) begin : g_sq2
    scp_sqrt_cell #(.RW(RW2)) u_cell (
      .clk(clk), .en(en),
      .rad_in(s2_rad[i]), .rem_in(s2_rem[i]), .root_in(s2_root[i]),
      .rad_out(s2_rad[i+1]), .rem_out(s2_rem[i+1]), .root_out(s2_root[i+1])
    );
  end

  // radial term in turns, rounded
  logic [PW-1:0]     rad_prod;
  logic [FRAC_W-1:0] radial;

  assign rad_prod = PW'(s2_root[RW2]) * PW'(RAD_GAIN) + PW'(64'd1 << 31);

  always_ff @(posedge clk) begin
    if (en) begin
      radial <= rad_prod[47:32];
    end
  end

  // phase fraction
  logic [FRAC_W-1:0]       ph_sum;
  logic [FRAC_W+ARM_W-1:0] ph_prod;
  logic [FRAC_W-1:0]       f16;
  logic                    f_last;

  assign ph_sum  = a16_d[FRAC_W:1] + radial;
  assign ph_prod = (FRAC_W+ARM_W)'(ph_sum) * (FRAC_W+ARM_W)'(arm_count);

  always_ff @(posedge clk) begin
    if (en) begin
      f16    <= ph_prod[FRAC_W-1:0];
      f_last <= a16_d[0];
    end
  end

  // fold the phase to a quarter turn
  logic [16:0] g17;
  logic [16:0] h17;
  logic        c_neg;

  assign g17   = f16[15] ? (17'h10000 - 17'(f16)) : 17'(f16);
  assign c_neg = (g17 > 17'd16384);
  assign h17   = c_neg ? (17'd32768 - g17) : g17;

  // cosine chain
  logic signed [ROT_W-1:0] rx [NS+1];
  logic signed [ROT_W-1:0] ry [NS+1];
  logic signed [ANG_W-1:0] rz [NS+1];

  assign rx[0] = INV_GAIN_Q30;
  assign ry[0] = '0;
  assign rz[0] = ANG_W'({h17[14:0], 16'b0});

  for (genvar i = 0; i < NS; i++) begin : g_rot
    scp_rot_cell #(.SHIFT(i)) u_cell (
      .clk(clk), .en(en),
      .x_in(rx[i]), .y_in(ry[i]), .z_in(rz[i]),
      .x_out(rx[i+1]), .y_out(ry[i+1]), .z_out(rz[i+1])
    );
  end

  logic [2:0] side_d;

  scp_delay #(.W(3), .DEPTH(NS)) u_side_dly (
    .clk(clk), .en(en),
    .d({c_neg, !f16[15], f_last}),
    .q(side_d)
  );

  // one plus cosine, clamped to [0, 2]
  logic signed [ROT_W+1:0] one_pc;
  logic [31:0]             onepc;
  logic                    p_fneg;
  logic                    p_last;

  assign one_pc = side_d[2] ? (35'sd1073741824 - (ROT_W+2)'(rx[NS]))
                            : (35'sd1073741824 + (ROT_W+2)'(rx[NS]));

  always_ff @(posedge clk) begin
    if (en) begin
      if (one_pc[ROT_W+1]) begin
        onepc <= '0;
      end else if (one_pc > 35'sd2147483648) begin
        onepc <= 32'h8000_0000;
      end else begin
        onepc <= one_pc[31:0];
      end
      p_fneg <= side_d[1];
      p_last <= side_d[0];
    end
  end

  // scale and sign, output register
  logic [63:0]             amp_prod;
  logic [VAL_W-1:0]        mag;
  logic signed [VAL_W-1:0] out_value;
  logic                    out_last;

  assign amp_prod = 64'(onepc) * 64'(HALF_AMP) + (64'd1 << 46);
  assign mag      = amp_prod[62:47];

  always_ff @(posedge clk) begin
    if (en) begin
      out_value <= p_fneg ? $signed(-mag) : $signed(mag);
      out_last  <= p_last;
    end
  end

  assign values.pattern_value = out_value;
  assign values.last_value    = out_last;

endmodule

// ===== design/scp_vec_cell.sv =====
// one cordic vectoring step: turns the vector toward the x axis and sums the angle
module scp_vec_cell import scp_pkg::*; #(
  parameter int XW    = 31,
  parameter int SHIFT = 0
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [XW-1:0]    x_in,
  input  logic signed [XW-1:0]    y_in,
  input  logic signed [ANG_W-1:0] z_in,
  output logic signed [XW-1:0]    x_out,
  output logic signed [XW-1:0]    y_out,
  output logic signed [ANG_W-1:0] z_out
);

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;

  assign xs = x_in >>> SHIFT;
  assign ys = y_in >>> SHIFT;

  // rotate against the sign of y
  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[XW-1]) begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + ATAN_TURNS[SHIFT];
      end else begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - ATAN_TURNS[SHIFT];
      end
    end
  end

endmodule

// ===== design/scp_rot_cell.sv =====
// one cordic rotation step: turns the vector by the remaining angle
module scp_rot_cell import scp_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [ROT_W-1:0] x_in,
  input  logic signed [ROT_W-1:0] y_in,
  input  logic signed [ANG_W-1:0] z_in,
  output logic signed [ROT_W-1:0] x_out,
  output logic signed [ROT_W-1:0] y_out,
  output logic signed [ANG_W-1:0] z_out
);

  logic signed [ROT_W-1:0] xs;
  logic signed [ROT_W-1:0] ys;

  assign xs = x_in >>> SHIFT;
  assign ys = y_in >>> SHIFT;

  // rotate by the sign of the residual angle
  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[ANG_W-1]) begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - ATAN_TURNS[SHIFT];
      end else begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + ATAN_TURNS[SHIFT];
      end
    end
  end

endmodule

// ===== design/scp_sqrt_cell.sv =====
// one digit of a restoring integer square root, two radicand bits per step
module scp_sqrt_cell #(
  parameter int RW = 21
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] rad_in,
  input  logic [RW+1:0]   rem_in,
  input  logic [RW-1:0]   root_in,
  output logic [2*RW-1:0] rad_out,
  output logic [RW+1:0]   rem_out,
  output logic [RW-1:0]   root_out
);

  logic [RW+3:0] r2;
  logic [RW+3:0] trial;
  logic          fits;

  assign r2    = {rem_in, rad_in[2*RW-1 -: 2]};
  assign trial = (RW+4)'({root_in, 2'b01});
  assign fits  = (r2 >= trial);

  // subtract the trial value when it fits and shift in the root bit
  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= {rad_in[2*RW-3:0], 2'b00};
      rem_out  <= fits ? (RW+2)'(r2 - trial) : (RW+2)'(r2);
      root_out <= {root_in[RW-2:0], fits};
    end
  end

endmodule

// ===== design/scp_div_cell.sv =====
// one quotient bit of a restoring divider; quotient bits shift in behind the dividend
module scp_div_cell import scp_pkg::*; #(
  parameter int NW = 45
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DIV_W-1:0] divisor,
  input  logic [NW-1:0]    num_in,
  input  logic [DIV_W-1:0] rem_in,
  output logic [NW-1:0]    num_out,
  output logic [DIV_W-1:0] rem_out
);

  logic [DIV_W:0] r2;
  logic           fits;

  assign r2   = {rem_in, num_in[NW-1]};
  assign fits = (r2 >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (en) begin
      num_out <= {num_in[NW-2:0], fits};
      rem_out <= fits ? DIV_W'(r2 - {1'b0, divisor}) : DIV_W'(r2);
    end
  end

endmodule

// ===== design/scp_delay.sv =====
// side-band delay line that keeps flags and the angle aligned with the long datapath
module scp_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[DEPTH-1];

endmodule

// ===== sim/tb_scp_if.sv =====
// testbench copy note: channel interfaces come from the design; this file holds a helper-free stub
`timescale 1ns / 1ps
package tb_scp_types;
  // one expected pattern result
  typedef struct packed {
    logic signed [15:0] pattern_value;
    logic               last_value;
  } pattern_result_t;
endpackage

// ===== sim/tb_spiral_cosine_pattern.sv =====
// testbench for the spiral cosine pattern generator: predicted results checked per transaction
`timescale 1ns / 1ps
module tb_spiral_cosine_pattern;
  import scp_pkg::*;
  import tb_scp_types::*;

  localparam int CBITS = 12;
  localparam int STAGES = 16;
  localparam int LATENCY = 110;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 0;
  logic rst = 1;
  logic wr_en = 0;
  logic [WR_INDEX_W-1:0] wr_index = '0;
  logic [WR_DATA_W-1:0] wr_data = '0;

  scp_point_if points();
  scp_value_if values();

  spiral_cosine_pattern #(.COORD_BITS(CBITS), .CORDIC_STAGES(STAGES)) dut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .points(points), .values(values)
  );

  always #2 clk = ~clk;

  // predictor copy of the configuration
  logic [11:0] cfg_cx, cfg_cy;
  logic [12:0] cfg_w, cfg_h;
  logic [6:0] cfg_arms;

  pattern_result_t pending_values[$];
  int mismatches = 0;
  int sent_points = 0;
  int got_values = 0;
  int idle_cycles = 0;
  bit hold_off = 0;
  bit rx_random = 1;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // cordic vectoring, angle in turns q.32
  function automatic longint angle_turns(longint x, longint y);
    longint z, xs, ys;
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += longint'(ATAN_TURNS[i]);
      end else begin
        x -= ys; y += xs; z -= longint'(ATAN_TURNS[i]);
      end
    end
    return z;
  endfunction

  // cordic rotation, cosine of a quarter-turn angle in q2.30
  function automatic longint cosine_q30(longint h);
    longint x, y, z, xs, ys;
    x = 652032874;
    y = 0;
    z = h * 65536;
    for (int i = 0; i < STAGES; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(ATAN_TURNS[i]);
      end else begin
        x += ys; y -= xs; z += longint'(ATAN_TURNS[i]);
      end
    end
    return x;
  endfunction

  function automatic pattern_result_t spiral_value(logic [11:0] px, logic [11:0] py,
                                                   logic lastp);
    pattern_result_t r;
    longint dx, dy, vx, a16, c, onepc, m;
    longint unsigned dist2, dq8, sum, ratio, root, radial, f16, g;
    bit neg;
    dx = longint'(cfg_cx) - longint'(px);
    dy = longint'(cfg_cy) - longint'(py);
    vx = -dx;
    if (vx == 0) a16 = (dy < 0) ? -16384 : 16384;
    else if (vx > 0) a16 = shr_floor(angle_turns(vx * 65536, dy * 65536) + 32768, 16);
    else a16 = shr_floor(angle_turns(-vx * 65536, -dy * 65536) + 32768, 16) + 32768;
    dist2 = dx * dx + dy * dy;
    dq8 = int_sqrt(dist2 << 16);
    sum = cfg_w + cfg_h;
    if (sum == 0) sum = 1;
    ratio = (dq8 << 24) / sum;
    root = int_sqrt(ratio);
    radial = (root * 64'd2050695827 + (64'd1 << 31)) >> 32;
    f16 = ((longint'(a16) + radial) * cfg_arms) & 64'hFFFF;
    g = (f16 >= 32768) ? 65536 - f16 : f16;
    neg = g > 16384;
    if (neg) g = 32768 - g;
    c = cosine_q30(g);
    onepc = neg ? 64'sd1073741824 - c : 64'sd1073741824 + c;
    if (onepc < 0) onepc = 0;
    if (onepc > 2 * 64'sd1073741824) onepc = 2 * 64'sd1073741824;
    m = (longint'(onepc) * 64'd2147054151 + (64'd1 << 46)) >> 47;
    r.pattern_value = 16'((f16 < 32768) ? -m : m);
    r.last_value = lastp;
    return r;
  endfunction

  // register write, only while idle
  task automatic write_reg(logic [WR_INDEX_W-1:0] idx, logic [WR_DATA_W-1:0] val);
    @(negedge clk);
    wr_en <= 1;
    wr_index <= idx;
    wr_data <= val;
    @(negedge clk);
    wr_en <= 0;
    case (idx)
      REG_CENTER_X: cfg_cx = val[11:0];
      REG_CENTER_Y: cfg_cy = val[11:0];
      REG_FRAME_WIDTH: cfg_w = val;
      REG_FRAME_HEIGHT: cfg_h = val;
      REG_ARM_COUNT: cfg_arms = val[6:0];
      default: ;
    endcase
  endtask

  task automatic configure(int cx, int cy, int w, int h, int arms);
    write_reg(REG_CENTER_X, WR_DATA_W'(cx));
    write_reg(REG_CENTER_Y, WR_DATA_W'(cy));
    write_reg(REG_FRAME_WIDTH, WR_DATA_W'(w));
    write_reg(REG_FRAME_HEIGHT, WR_DATA_W'(h));
    write_reg(REG_ARM_COUNT, WR_DATA_W'(arms));
  endtask

  // one point transaction, with an optional random gap before it; valid stays up for the next one
  task automatic send_point(logic [11:0] px, logic [11:0] py, logic lastp, bit gaps = 1);
    int gap;
    gap = gaps ? ($urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0) : 0;
    @(negedge clk);
    if (gap != 0) begin
      points.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    points.valid <= 1;
    points.point_x <= px;
    points.point_y <= py;
    points.last_point <= lastp;
    @(posedge clk);
    while (!points.ready) @(posedge clk);
    pending_values.push_back(spiral_value(px, py, lastp));
    sent_points++;
  endtask

  task automatic drain();
    @(negedge clk);
    points.valid <= 0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic test_directed_points();
    logic [11:0] ext[4] = '{12'd0, 12'd1, 12'd2048, 12'd4095};
    configure(2048, 2048, 640, 480, 4);
    send_point(2048, 2048, 1'b1);   // zero offset
    send_point(2048, 100, 1'b0);    // vertical, above
    send_point(2048, 4000, 1'b0);   // vertical, below
    send_point(100, 2048, 1'b0);    // left half
    send_point(4000, 2048, 1'b1);   // right half
    foreach (ext[i]) send_point(ext[i], ext[3 - i], i[0]);
    drain();
  endtask

  task automatic test_config_extremes();
    configure(0, 0, 1, 1, 1);
    send_point(4095, 4095, 1); send_point(0, 0, 0); send_point(1, 0, 1);
    drain();
    configure(4095, 4095, 4096, 4096, 64);
    send_point(0, 0, 0); send_point(4095, 0, 1); send_point(0, 4095, 0);
    drain();
    configure(100, 200, 0, 0, 0);   // zero frame size and zero arms
    send_point(7, 9, 1); send_point(4095, 4095, 0);
    drain();
    configure(4095, 0, 8191, 8191, 127);
    send_point(0, 4095, 1); send_point(123, 456, 0);
    drain();
  endtask

  task automatic test_random_points();
    for (int phase = 0; phase < 4; phase++) begin
      configure($urandom_range(0, 4095), $urandom_range(0, 4095),
                $urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(1, 64));
      for (int n = 0; n < 220; n++)
        send_point(12'($urandom), 12'($urandom), 1'($urandom_range(0, 1)), phase != 2);
      drain();
    end
  endtask

  // long receiver hold-off while points keep arriving
  task automatic test_backpressure();
    configure(1000, 3000, 1920, 1080, 8);
    rx_random = 0;
    hold_off = 1;
    fork
      for (int n = 0; n < 200; n++)
        send_point(12'($urandom), 12'($urandom), 1'($urandom_range(0, 1)), 0);
      begin
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
    join
    rx_random = 1;
    drain();
  endtask

  // receiver ready pattern
  initial begin
    int stall;
    values.ready = 0;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        values.ready <= 0;
        @(negedge clk);
      end else begin
        stall = (rx_random && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        values.ready <= (stall == 0);
        @(negedge clk);
        if (stall != 0) begin
          repeat (stall - 1) @(negedge clk);
          values.ready <= 1;
          @(negedge clk);
        end
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    pattern_result_t exp_v;
    if (!rst && values.valid && values.ready) begin
      got_values++;
      if (pending_values.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected value transaction %0d", values.pattern_value);
      end else begin
        exp_v = pending_values.pop_front();
        if (values.pattern_value !== exp_v.pattern_value ||
            values.last_value !== exp_v.last_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %0d last %0b, got value %0d last %0b",
                     exp_v.pattern_value, exp_v.last_value,
                     values.pattern_value, values.last_value);
        end
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((points.valid && points.ready) || (values.valid && values.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d values pending", pending_values.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    points.valid = 0;
    points.point_x = '0;
    points.point_y = '0;
    points.last_point = 0;
    cfg_cx = CENTER_X_RST;
    cfg_cy = CENTER_Y_RST;
    cfg_w = FRAME_WIDTH_RST;
    cfg_h = FRAME_HEIGHT_RST;
    cfg_arms = ARM_COUNT_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // reset defaults first
    send_point(320, 10, 0);
    send_point(0, 0, 1);
    drain();
    test_directed_points();
    test_config_extremes();
    test_random_points();
    test_backpressure();
    if (pending_values.size() != 0) mismatches += pending_values.size();
    $display("covered %0d points and %0d values over directed, extreme, random", sent_points,
             got_values);
    $display("and stalled-output settings; %0d mismatches", mismatches);
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== spiral_cosine_pattern.f =====
design/scp_pkg.sv
design/scp_if.sv
design/scp_vec_cell.sv
design/scp_rot_cell.sv
design/scp_sqrt_cell.sv
design/scp_div_cell.sv
design/scp_delay.sv
design/spiral_cosine_pattern.sv
sim/tb_scp_if.sv
sim/tb_spiral_cosine_pattern.sv
